[sv/assert_macros.svh]
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/bcde_pkg.sv]
package bcde_pkg;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_BUILD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FEW   = 2'd3
  } status_e;

  typedef struct packed {
    logic push_wr;
    logic load;
    logic take;
    logic shift1;
    logic shift2;
  } cell_ctl_t;

  // unsigned Q1.16 one
  localparam logic [16:0] FRAC_ONE = 17'd65536;
  // signed Q2.14 one
  localparam logic signed [17:0] Q14_ONE = 18'sd16384;

endpackage

[sv/bcde_lerp.sv]
module bcde_lerp #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic signed [15:0]    a_i,
  input  logic signed [15:0]    b_i,
  input  logic [T_FRAC_BITS:0]  t_i,
  output logic signed [15:0]    r_o
);
  localparam int PW = T_FRAC_BITS + 19;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

  logic signed [16:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [18:0]   delta;
  logic signed [19:0]   sum;

  always_comb begin
    diff     = {b_i[15], b_i} - {a_i[15], a_i};
    prod     = PW'(diff) * PW'($signed({1'b0, t_i}));
    prod_rnd = prod + HALF;
    // dropping the low bits of a two's complement word rounds toward minus infinity
    delta    = prod_rnd[PW-1:T_FRAC_BITS];
    sum      = 20'(a_i) + 20'(delta);
    if (sum > 20'sd32767) begin
      r_o = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      r_o = 16'sh8000;
    end else begin
      r_o = sum[15:0];
    end
  end

endmodule

[sv/bcde_cell.sv]
module bcde_cell (
  input  logic               clk_i,
  input  bcde_pkg::cell_ctl_t ctl_i,
  input  bcde_pkg::point_t   push_pt_i,
  input  bcde_pkg::point_t   next1_i,
  input  bcde_pkg::point_t   next2_i,
  input  bcde_pkg::point_t   result_i,
  output bcde_pkg::point_t   ctrl_o,
  output bcde_pkg::point_t   work_o
);
  import bcde_pkg::*;

  point_t ctrl_q, ctrl_d;
  point_t work_q, work_d;

  always_comb begin
    ctrl_d = ctrl_q;
    if (ctl_i.push_wr) begin
      ctrl_d = push_pt_i;
    end
  end

  // the new level is built at the tail while the old one moves toward the head
  always_comb begin
    work_d = work_q;
    if (ctl_i.load) begin
      work_d = ctrl_q;
    end else if (ctl_i.take) begin
      work_d = result_i;
    end else if (ctl_i.shift2) begin
      work_d = next2_i;
    end else if (ctl_i.shift1) begin
      work_d = next1_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_d;
    work_q <= work_d;
  end

  assign ctrl_o = ctrl_q;
  assign work_o = work_q;

endmodule

[sv/bezier_curve_evaluator_top.sv]
// Bezier curve evaluator, de Casteljau in fixed point.
// Input channel (in_valid_i / in_stall_o) carries mode, window fractions and t;
// output channel (out_valid_o / out_stall_i) carries result points with level,
// position, point count, status and a last flag on the final result of an item.
// Push, pop and any item refused with a status are answered from idle: the
// result is registered and shows in the cycle after the transfer, and a new item
// can follow in the next cycle if that result is not stalled.
// Sample and construct over n points run through n(n-1)/2 interpolation steps,
// one per cycle while no result is stalled, in a row of cells that each hold
// one control point and one work point; the head pair feeds one interpolation
// unit per coordinate and the cells shift toward the head while results fill in
// at the tail. The sample result, or the final construct point, is registered
// from the final step, and the next item is taken once the evaluator is idle.
// While the receiver stalls a waiting result, every interpolation step waits,
// and no new item is taken until the output register can be loaded.
// Reset empties the point list and returns to idle; point storage is not cleared.
`include "assert_macros.svh"

module bezier_curve_evaluator_top #(
  parameter int MAX_POINTS  = 8,
  parameter int T_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [16:0] x_frac_i,
  input  logic [16:0] y_frac_i,
  input  logic [16:0] t_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [2:0]  level_o,
  output logic [2:0]  position_o,
  output logic [3:0]  point_count_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import bcde_pkg::*;

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int TW  = T_FRAC_BITS + 1;
  localparam int TXW = (TW > 17) ? TW : 17;
  localparam logic [TXW-1:0] T_ONE = TXW'(1) << T_FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] lvl_q, lvl_d;
  logic [TW-1:0] t_q, t_d;
  logic          all_q, all_d;

  logic          out_valid_q;
  point_t        out_pt_q;
  logic [2:0]    out_level_q;
  logic [2:0]    out_pos_q;
  logic [3:0]    out_count_q;
  logic [1:0]    out_status_q;
  logic          out_last_q;

  logic          can_emit, in_acc, step, last_in_level, final_step;
  logic          push_wr, load;
  logic [CW-1:0] wr_idx;
  logic [IW-1:0] pop_idx;
  logic [TXW-1:0] t_ext, t_clamp;

  logic          emit;
  point_t        emit_pt;
  logic [2:0]    emit_level, emit_pos;
  logic [3:0]    emit_count;
  status_e       emit_status;
  logic          emit_last;

  logic [16:0]   xc, yc, yinc;
  logic signed [17:0] px_w, py_w;
  point_t        push_pt, result_pt;

  point_t        cell_ctrl [MAX_POINTS];
  point_t        cell_work [MAX_POINTS];
  cell_ctl_t     cell_ctl  [MAX_POINTS];

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step       = (state_q == ST_RUN) && can_emit;

  assign last_in_level = (pos_q + CW'(2)) == len_q;
  assign final_step    = last_in_level && (len_q == CW'(2));
  assign wr_idx        = last_in_level ? (len_q - CW'(2)) : (len_q - CW'(1));
  assign pop_idx       = IW'(held_q - CW'(1));

  // push mapping: x' = 2x - 1, y' = 1 - 2y in Q2.14
  always_comb begin
    xc      = (x_frac_i > FRAC_ONE) ? FRAC_ONE : x_frac_i;
    yc      = (y_frac_i > FRAC_ONE) ? FRAC_ONE : y_frac_i;
    yinc    = yc + 17'd1;
    px_w    = $signed({2'b00, xc[16:1]}) - Q14_ONE;
    py_w    = Q14_ONE - $signed({2'b00, yinc[16:1]});
    push_pt.x = px_w[15:0];
    push_pt.y = py_w[15:0];
  end

  always_comb begin
    t_ext   = TXW'(t_value_i);
    t_clamp = (t_ext > T_ONE) ? T_ONE : t_ext;
  end

  bcde_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_x (
    .a_i(cell_work[0].x),
    .b_i(cell_work[1].x),
    .t_i(t_q),
    .r_o(result_pt.x)
  );

  bcde_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_y (
    .a_i(cell_work[0].y),
    .b_i(cell_work[1].y),
    .t_i(t_q),
    .r_o(result_pt.y)
  );

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      cell_ctl[k].push_wr = push_wr && (held_q[IW-1:0] == IW'(k));
      cell_ctl[k].load    = load;
      cell_ctl[k].take    = step && (wr_idx == CW'(k));
      cell_ctl[k].shift1  = step && !last_in_level;
      cell_ctl[k].shift2  = step && last_in_level;
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    point_t next1, next2;
    if (k + 1 < MAX_POINTS) begin : g_n1
      assign next1 = cell_work[k+1];
    end else begin : g_n1_end
      assign next1 = '0;
    end
    if (k + 2 < MAX_POINTS) begin : g_n2
      assign next2 = cell_work[k+2];
    end else begin : g_n2_end
      assign next2 = '0;
    end
    bcde_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (cell_ctl[k]),
      .push_pt_i(push_pt),
      .next1_i  (next1),
      .next2_i  (next2),
      .result_i (result_pt),
      .ctrl_o   (cell_ctrl[k]),
      .work_o   (cell_work[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    len_d       = len_q;
    pos_d       = pos_q;
    lvl_d       = lvl_q;
    t_d         = t_q;
    all_d       = all_q;
    push_wr     = 1'b0;
    load        = 1'b0;
    emit        = 1'b0;
    emit_pt     = '0;
    emit_level  = '0;
    emit_pos    = '0;
    emit_count  = 4'(held_q);
    emit_status = STAT_OK;
    emit_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_e'(mode_i)) inside
            MODE_PUSH: begin
              emit = 1'b1;
              if (held_q == CW'(MAX_POINTS)) begin
                emit_status = STAT_FULL;
              end else begin
                push_wr    = 1'b1;
                held_d     = held_q + CW'(1);
                emit_pt    = push_pt;
                emit_pos   = 3'(held_q);
                emit_count = 4'(held_q + CW'(1));
              end
            end
            MODE_POP: begin
              emit = 1'b1;
              if (held_q == '0) begin
                emit_status = STAT_EMPTY;
              end else begin
                held_d     = held_q - CW'(1);
                emit_pt    = cell_ctrl[pop_idx];
                emit_count = 4'(held_q - CW'(1));
              end
            end
            MODE_SAMPLE, MODE_BUILD: begin
              if (held_q < CW'(2)) begin
                emit        = 1'b1;
                emit_status = STAT_FEW;
              end else begin
                load    = 1'b1;
                state_d = ST_RUN;
                len_d   = held_q;
                pos_d   = '0;
                lvl_d   = CW'(1);
                t_d     = t_clamp[TW-1:0];
                all_d   = (mode_e'(mode_i) == MODE_BUILD);
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (step) begin
          if (all_q || final_step) begin
            emit       = 1'b1;
            emit_pt    = result_pt;
            emit_level = 3'(lvl_q);
            emit_pos   = 3'(pos_q);
            emit_last  = final_step;
          end
          if (last_in_level) begin
            len_d = len_q - CW'(1);
            pos_d = '0;
            lvl_d = lvl_q + CW'(1);
          end else begin
            pos_d = pos_q + CW'(1);
          end
          if (final_step) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      lvl_q       <= '0;
      all_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      lvl_q   <= lvl_d;
      all_q   <= all_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (emit) begin
      out_pt_q     <= emit_pt;
      out_level_q  <= emit_level;
      out_pos_q    <= emit_pos;
      out_count_q  <= emit_count;
      out_status_q <= emit_status;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = out_pt_q.x;
  assign point_y_o     = out_pt_q.y;
  assign level_o       = out_level_q;
  assign position_o    = out_pos_q;
  assign point_count_o = out_count_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

  `ASSERT_ALWAYS(a_held_range, clk_i, !rst_ni || held_q <= CW'(MAX_POINTS), "point count above capacity")
  `ASSERT_RST(a_run_bounds, clk_i, rst_ni,
    (state_q == ST_RUN) |-> (len_q >= CW'(2) && (pos_q + CW'(2)) <= len_q),
    "step counters out of range")
  `ASSERT_RST(a_run_holds_list, clk_i, rst_ni, (state_q == ST_RUN) |=> $stable(held_q),
    "point list changed during evaluation")
  `ASSERT_RST(a_final_result, clk_i, rst_ni,
    (step && final_step) |=> (state_q == ST_IDLE && out_valid_o && last_o),
    "final step did not close the item")

endmodule
